/* rtl/core/q248_pkg.sv */
// Shared types, constants and saturation helpers for the Q24.8 fixed-point ALU.
// No dependencies; used by q248_prep, q248_cell, q248_post and fixed_point_q24_8_alu.
package q248_pkg;

    localparam int FRAC_BITS  = 8;
    localparam int WORD_BITS  = 32;
    // quotient bits of |a| << FRAC_BITS divided by |b|
    localparam int QUO_BITS   = WORD_BITS + FRAC_BITS;
    localparam int PROD_BITS  = 2 * WORD_BITS;
    localparam int S_TDATA_W  = 2 * WORD_BITS;
    localparam int M_TDATA_W  = ((WORD_BITS + 1 + 7) / 8) * 8;
    localparam int FIFO_DEPTH = 64;
    localparam int FIFO_AW    = 6;

    localparam logic [FIFO_AW:0] CREDIT_MAX = (FIFO_AW + 1)'(FIFO_DEPTH);

    localparam logic signed [QUO_BITS:0] S_MAX =
        {{(QUO_BITS - WORD_BITS + 2){1'b0}}, {(WORD_BITS - 1){1'b1}}};
    localparam logic signed [QUO_BITS:0] S_MIN =
        {{(QUO_BITS - WORD_BITS + 2){1'b1}}, {(WORD_BITS - 1){1'b0}}};
    localparam logic [PROD_BITS-1:0] MAG_MAX =
        {{(PROD_BITS - WORD_BITS + 1){1'b0}}, {(WORD_BITS - 1){1'b1}}};
    localparam logic [PROD_BITS-1:0] MAG_MIN =
        {{(PROD_BITS - WORD_BITS){1'b0}}, 1'b1, {(WORD_BITS - 1){1'b0}}};
    localparam logic [PROD_BITS-1:0] ROUND_HALF = PROD_BITS'(1) << (FRAC_BITS - 1);

    localparam logic [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS - 1){1'b1}}};
    localparam logic [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS - 1){1'b0}}};

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_SAT  = 2'd1;
    localparam logic [1:0] ST_DIV0 = 2'd2;

    typedef enum logic [3:0] {
        CMD_ADD  = 4'd0,
        CMD_SUB  = 4'd1,
        CMD_MUL  = 4'd2,
        CMD_DIV  = 4'd3,
        CMD_GT   = 4'd4,
        CMD_LT   = 4'd5,
        CMD_GE   = 4'd6,
        CMD_LE   = 4'd7,
        CMD_EQ   = 4'd8,
        CMD_NE   = 4'd9,
        CMD_MIN  = 4'd10,
        CMD_MAX  = 4'd11,
        CMD_INC  = 4'd12,
        CMD_DEC  = 4'd13,
        CMD_ITOF = 4'd14,
        CMD_FTOI = 4'd15
    } cmd_t;

    // what is left to do for an item once it leaves the front stage
    typedef enum logic [2:0] {
        KIND_DONE = 3'b001,
        KIND_MUL  = 3'b010,
        KIND_DIV  = 3'b100
    } kind_t;

    typedef struct packed {
        kind_t                kind;
        logic                 neg;
        logic [QUO_BITS-1:0]  x;      // dividend/quotient shift word, or |a| for mul
        logic [WORD_BITS-1:0] d;      // |b|
        logic [WORD_BITS-1:0] rem;    // partial remainder
        logic [WORD_BITS-1:0] res;    // finished result for KIND_DONE
        logic                 flag;
        logic [1:0]           status;
    } cell_t;

    typedef struct packed {
        logic [WORD_BITS-1:0] res;
        logic                 flag;
        logic [1:0]           status;
    } out_t;

    typedef struct packed {
        logic [WORD_BITS-1:0] val;
        logic                 hit;
    } sat_t;

    function automatic sat_t sat_signed(input logic signed [QUO_BITS:0] v);
        sat_t s;
        s.hit = 1'b1;
        if (v > S_MAX) begin
            s.val = WORD_MAX;
        end
        else if (v < S_MIN) begin
            s.val = WORD_MIN;
        end
        else begin
            s.val = v[WORD_BITS-1:0];
            s.hit = 1'b0;
        end
        return s;
    endfunction

    function automatic sat_t sat_mag(input logic [PROD_BITS-1:0] m, input logic neg);
        sat_t s;
        s.hit = 1'b1;
        if (neg) begin
            if (m > MAG_MIN) begin
                s.val = WORD_MIN;
            end
            else begin
                s.val = {WORD_BITS{1'b0}} - m[WORD_BITS-1:0];
                s.hit = 1'b0;
            end
        end
        else if (m > MAG_MAX) begin
            s.val = WORD_MAX;
        end
        else begin
            s.val = m[WORD_BITS-1:0];
            s.hit = 1'b0;
        end
        return s;
    endfunction

endpackage

/* rtl/core/fixed_point_q24_8_alu.sv */
// Top level of the signed Q24.8 fixed-point ALU: front stage, divider cell chain,
// back end and output buffer. Depends on q248_pkg, q248_prep, q248_cell, q248_post.
//
//   channel  | dir | bits                    | contents
//   s_*      | in  | tdata 64, tuser 4       | operand_a, operand_b; command
//   m_*      | out | tdata 40, tuser 2       | result, flag; status
//
// One transfer per cycle in while s_tready is high, one per cycle out while m_tready is high.
// Every command goes through the front stage, the 40-cell divider chain and the back
// end, so results stay in order.
// Up to 64 items may be outstanding; s_tready drops only when 64 are unclaimed.
// Reset clears valid bits, buffer pointers and the credit count; no clearing pass.
module fixed_point_q24_8_alu
    import q248_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [31:0] operand_a, [63:32] operand_b
    input  logic [3:0]            s_tuser,   // [3:0] command
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [31:0] result, [32] flag, zero pad
    output logic [1:0]            m_tuser    // [1:0] status
);

    logic                    s_xfer;
    logic                    m_xfer;
    logic [QUO_BITS:0]       chain_valid;
    cell_t                   chain_data [0:QUO_BITS];
    logic                    post_valid;
    out_t                    post_data;

    out_t                    fifo_mem [0:FIFO_DEPTH-1];
    logic [FIFO_AW-1:0]      wr_ptr_reg;
    logic [FIFO_AW-1:0]      rd_ptr_reg;
    logic [FIFO_AW:0]        fcnt_reg;
    logic [FIFO_AW:0]        fcnt_next;
    logic [FIFO_AW:0]        credit_reg;
    logic [FIFO_AW:0]        credit_next;
    logic                    pop;
    logic                    m_tvalid_reg;
    out_t                    out_data_reg;

    assign s_tready = credit_reg < CREDIT_MAX;
    assign s_xfer   = s_tvalid && s_tready;
    assign m_xfer   = m_tvalid_reg && m_tready;

    q248_prep u_prep
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_xfer),
        .cmd       (cmd_t'(s_tuser)),
        .a         (s_tdata[WORD_BITS-1:0]),
        .b         (s_tdata[S_TDATA_W-1:WORD_BITS]),
        .out_valid (chain_valid[0]),
        .out_data  (chain_data[0])
    );

    for (genvar i = 0; i < QUO_BITS; i++) begin : g_cell
        q248_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[i]),
            .in_data   (chain_data[i]),
            .out_valid (chain_valid[i+1]),
            .out_data  (chain_data[i+1])
        );
    end

    q248_post u_post
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (chain_valid[QUO_BITS]),
        .in_data   (chain_data[QUO_BITS]),
        .out_valid (post_valid),
        .out_data  (post_data)
    );

    // output buffer; credits guarantee it never overflows, so the chain never stalls
    assign pop = (fcnt_reg != '0) && (!m_tvalid_reg || m_tready);

    always_comb
    begin
        fcnt_next = fcnt_reg;
        if (post_valid && !pop) begin
            fcnt_next = fcnt_reg + 1'b1;
        end
        else if (!post_valid && pop) begin
            fcnt_next = fcnt_reg - 1'b1;
        end

        credit_next = credit_reg;
        if (s_xfer && !m_xfer) begin
            credit_next = credit_reg + 1'b1;
        end
        else if (!s_xfer && m_xfer) begin
            credit_next = credit_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (post_valid) begin
            fifo_mem[wr_ptr_reg] <= post_data;
        end
        if (pop) begin
            out_data_reg <= fifo_mem[rd_ptr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fcnt_reg     <= '0;
            credit_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else begin
            if (post_valid) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            fcnt_reg   <= fcnt_next;
            credit_reg <= credit_next;
            if (pop) begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W - WORD_BITS - 1){1'b0}}, out_data_reg.flag,
                       out_data_reg.res};
    assign m_tuser  = out_data_reg.status;

    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        credit_reg <= CREDIT_MAX)
        else $error("outstanding count above buffer depth");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        post_valid |-> fcnt_reg < CREDIT_MAX)
        else $error("result written into a full buffer");

    a_buffer_within_credit: assert property (@(posedge clk) disable iff (!rst_n)
        fcnt_reg <= credit_reg)
        else $error("buffer holds more results than items outstanding");

    a_out_has_credit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg |-> credit_reg != '0)
        else $error("result presented with no item outstanding");

endmodule

/* rtl/core/q248_prep.sv */
// Front stage of the Q24.8 ALU: decodes the command, finishes every op but mul and a
// nonzero div, and sets up magnitudes for those two. Depends on q248_pkg.
module q248_prep
    import q248_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  cmd_t                        cmd,
    input  logic signed [WORD_BITS-1:0] a,
    input  logic signed [WORD_BITS-1:0] b,
    output logic                        out_valid,
    output cell_t                       out_data
);

    localparam logic signed [QUO_BITS:0] ONE_W = 1;

    logic                        valid_reg;
    cell_t                       data_reg;
    cell_t                       data_next;
    logic signed [QUO_BITS:0]    ae;
    logic signed [QUO_BITS:0]    be;
    logic signed [QUO_BITS:0]    wide;
    logic                        use_wide;
    logic [WORD_BITS-1:0]        mag_a;
    logic [WORD_BITS-1:0]        mag_b;
    logic [WORD_BITS-1:0]        trunc_mag;
    logic [WORD_BITS-1:0]        ftoi;
    logic                        lt;
    logic                        eq;
    sat_t                        sv;

    always_comb
    begin
        ae        = {{(QUO_BITS - WORD_BITS + 1){a[WORD_BITS-1]}}, a};
        be        = {{(QUO_BITS - WORD_BITS + 1){b[WORD_BITS-1]}}, b};
        mag_a     = a[WORD_BITS-1] ? ({WORD_BITS{1'b0}} - a) : a;
        mag_b     = b[WORD_BITS-1] ? ({WORD_BITS{1'b0}} - b) : b;
        trunc_mag = mag_a >> FRAC_BITS;
        ftoi      = a[WORD_BITS-1] ? ({WORD_BITS{1'b0}} - trunc_mag) : trunc_mag;
        lt        = a < b;
        eq        = a == b;

        wide     = ae;
        use_wide = 1'b0;

        data_next        = '0;
        data_next.kind   = KIND_DONE;
        data_next.neg    = a[WORD_BITS-1] ^ b[WORD_BITS-1];
        data_next.x      = {{FRAC_BITS{1'b0}}, mag_a};
        data_next.d      = mag_b;
        data_next.status = ST_OK;

        case (cmd)
            CMD_ADD:
            begin
                wide     = ae + be;
                use_wide = 1'b1;
            end
            CMD_SUB:
            begin
                wide     = ae - be;
                use_wide = 1'b1;
            end
            CMD_MUL:  data_next.kind = KIND_MUL;
            CMD_DIV:
            begin
                if (b == '0) begin
                    data_next.status = ST_DIV0;
                end
                else begin
                    data_next.kind = KIND_DIV;
                    data_next.x    = {mag_a, {FRAC_BITS{1'b0}}};
                end
            end
            CMD_GT:   data_next.flag = !lt && !eq;
            CMD_LT:   data_next.flag = lt;
            CMD_GE:   data_next.flag = !lt;
            CMD_LE:   data_next.flag = lt || eq;
            CMD_EQ:   data_next.flag = eq;
            CMD_NE:   data_next.flag = !eq;
            CMD_MIN:
            begin
                wide     = lt ? ae : be;
                use_wide = 1'b1;
            end
            CMD_MAX:
            begin
                wide     = lt ? be : ae;
                use_wide = 1'b1;
            end
            CMD_INC:
            begin
                wide     = ae + ONE_W;
                use_wide = 1'b1;
            end
            CMD_DEC:
            begin
                wide     = ae - ONE_W;
                use_wide = 1'b1;
            end
            CMD_ITOF:
            begin
                wide     = ae <<< FRAC_BITS;
                use_wide = 1'b1;
            end
            CMD_FTOI: data_next.res = ftoi;
            default:  data_next.res = ftoi;
        endcase

        sv = sat_signed(wide);
        if (use_wide) begin
            data_next.res    = sv.val;
            data_next.status = sv.hit ? ST_SAT : ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end
        else begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

/* rtl/core/q248_cell.sv */
// One cell of the divider chain: a restoring step producing one quotient bit.
// Items that are not divisions pass through unchanged. Depends on q248_pkg.
module q248_cell
    import q248_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  cell_t in_data,
    output logic  out_valid,
    output cell_t out_data
);

    logic                 valid_reg;
    cell_t                data_reg;
    cell_t                data_next;
    logic [WORD_BITS:0]   shifted;
    logic [WORD_BITS:0]   trial;

    always_comb
    begin
        shifted   = {in_data.rem, in_data.x[QUO_BITS-1]};
        trial     = shifted - {1'b0, in_data.d};
        data_next = in_data;
        if (in_data.kind == KIND_DIV) begin
            // borrow means the divisor did not fit
            if (!trial[WORD_BITS]) begin
                data_next.rem = trial[WORD_BITS-1:0];
            end
            else begin
                data_next.rem = shifted[WORD_BITS-1:0];
            end
            data_next.x = {in_data.x[QUO_BITS-2:0], !trial[WORD_BITS]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end
        else begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

/* rtl/core/q248_post.sv */
// Back end of the Q24.8 ALU: multiplier, quotient rounding, product rounding and
// final saturation over two registered stages. Depends on q248_pkg.
module q248_post
    import q248_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  cell_t in_data,
    output logic  out_valid,
    output out_t  out_data
);

    logic                  v1_reg;
    kind_t                 kind1_reg;
    logic                  neg1_reg;
    logic [PROD_BITS-1:0]  mag1_reg;
    logic [PROD_BITS-1:0]  mag1_next;
    out_t                  done1_reg;
    logic                  round_up;
    logic [QUO_BITS-1:0]   quo;
    logic                  v2_reg;
    out_t                  out2_reg;
    out_t                  out2_next;
    logic [PROD_BITS-1:0]  mag2;
    sat_t                  sv;

    // stage 1: product or rounded quotient magnitude
    always_comb
    begin
        round_up = {in_data.rem, 1'b0} >= {1'b0, in_data.d};
        quo      = in_data.x + QUO_BITS'(round_up);
        if (in_data.kind == KIND_MUL) begin
            mag1_next = PROD_BITS'(in_data.x[WORD_BITS-1:0]) * PROD_BITS'(in_data.d);
        end
        else begin
            mag1_next = {{(PROD_BITS - QUO_BITS){1'b0}}, quo};
        end
    end

    always_ff @(posedge clk)
    begin
        kind1_reg        <= in_data.kind;
        neg1_reg         <= in_data.neg;
        mag1_reg         <= mag1_next;
        done1_reg.res    <= in_data.res;
        done1_reg.flag   <= in_data.flag;
        done1_reg.status <= in_data.status;
    end

    // stage 2: round half away from zero for products, then clamp
    always_comb
    begin
        if (kind1_reg == KIND_MUL) begin
            mag2 = (mag1_reg + ROUND_HALF) >> FRAC_BITS;
        end
        else begin
            mag2 = mag1_reg;
        end
        sv = sat_mag(mag2, neg1_reg);
        if (kind1_reg == KIND_DONE) begin
            out2_next = done1_reg;
        end
        else begin
            out2_next.res    = sv.val;
            out2_next.flag   = 1'b0;
            out2_next.status = sv.hit ? ST_SAT : ST_OK;
        end
    end

    always_ff @(posedge clk)
    begin
        out2_reg <= out2_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign out_data  = out2_reg;

endmodule

/* tb/fixed_point_q24_8_alu_test.sv */
// Stream-level testbench for the Q24.8 fixed-point ALU (fixed_point_q24_8_alu).
// Needs q248_pkg for the command codes and status values; a directed table runs
// first, then random traffic, with idles on both sides and a scoreboard check.
module fixed_point_q24_8_alu_test;
    import q248_pkg::*;

    typedef longint unsigned u64_t;

    typedef struct packed {
        logic [WORD_BITS-1:0] res;
        logic                 flag;
        logic [1:0]           status;
    } alu_result_t;

    typedef struct packed {
        cmd_t                 op;
        logic [WORD_BITS-1:0] a;
        logic [WORD_BITS-1:0] b;
        logic                 typed;    // 1: want is exact, 0: use the predictor
        alu_result_t          want;
    } alu_vector_t;

    localparam int     NUM_VECTORS  = 25;
    localparam int     NUM_RANDOM   = 550;
    localparam int     STALL_LIMIT  = 2000;
    localparam int     DRAIN_CYCLES = 60;
    localparam longint WORD_HI      = (64'sd1 <<< (WORD_BITS - 1)) - 1;
    localparam longint WORD_LO      = -WORD_HI - 1;

    localparam alu_vector_t VECTORS [0:NUM_VECTORS-1] = '{
        '{CMD_ADD,  32'h7fffffff, 32'h00000001, 1'b1, '{32'h7fffffff, 1'b0, ST_SAT}},
        '{CMD_ADD,  32'h80000000, 32'hffffffff, 1'b1, '{32'h80000000, 1'b0, ST_SAT}},
        '{CMD_SUB,  32'h80000000, 32'h00000001, 1'b1, '{32'h80000000, 1'b0, ST_SAT}},
        '{CMD_MUL,  32'h7fffffff, 32'h7fffffff, 1'b1, '{32'h7fffffff, 1'b0, ST_SAT}},
        '{CMD_MUL,  32'hfffffe80, 32'h00000280, 1'b0, '0},
        '{CMD_MUL,  32'h00000001, 32'h00000080, 1'b0, '0},
        '{CMD_MUL,  32'h80000000, 32'h00000100, 1'b0, '0},
        '{CMD_DIV,  32'h00000500, 32'h00000000, 1'b1, '{32'h00000000, 1'b0, ST_DIV0}},
        '{CMD_DIV,  32'h80000000, 32'hffffffff, 1'b1, '{32'h7fffffff, 1'b0, ST_SAT}},
        '{CMD_DIV,  32'h00000001, 32'h00000200, 1'b0, '0},
        '{CMD_DIV,  32'hffffff00, 32'h00000300, 1'b0, '0},
        '{CMD_GT,   32'h7fffffff, 32'h80000000, 1'b1, '{32'h00000000, 1'b1, ST_OK}},
        '{CMD_LT,   32'h7fffffff, 32'h80000000, 1'b1, '{32'h00000000, 1'b0, ST_OK}},
        '{CMD_GE,   32'h12345678, 32'h12345678, 1'b1, '{32'h00000000, 1'b1, ST_OK}},
        '{CMD_LE,   32'h80000000, 32'h7fffffff, 1'b1, '{32'h00000000, 1'b1, ST_OK}},
        '{CMD_EQ,   32'h80000000, 32'h80000000, 1'b1, '{32'h00000000, 1'b1, ST_OK}},
        '{CMD_NE,   32'h00000000, 32'h00000000, 1'b1, '{32'h00000000, 1'b0, ST_OK}},
        '{CMD_MIN,  32'h80000000, 32'h7fffffff, 1'b1, '{32'h80000000, 1'b0, ST_OK}},
        '{CMD_MAX,  32'h80000000, 32'h7fffffff, 1'b1, '{32'h7fffffff, 1'b0, ST_OK}},
        '{CMD_INC,  32'h7fffffff, 32'h00000000, 1'b1, '{32'h7fffffff, 1'b0, ST_SAT}},
        '{CMD_DEC,  32'h80000000, 32'hffffffff, 1'b1, '{32'h80000000, 1'b0, ST_SAT}},
        '{CMD_ITOF, 32'h00000001, 32'h00000000, 1'b1, '{32'h00000100, 1'b0, ST_OK}},
        '{CMD_ITOF, 32'h00800000, 32'h00000000, 1'b1, '{32'h7fffffff, 1'b0, ST_SAT}},
        '{CMD_FTOI, 32'hffffffff, 32'h00000000, 1'b1, '{32'h00000000, 1'b0, ST_OK}},
        '{CMD_FTOI, 32'h80000000, 32'h00000000, 1'b1, '{32'hff800000, 1'b0, ST_OK}}
    };

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [3:0]           s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [1:0]           m_tuser;

    alu_result_t pending_results [$];
    int          fail_count = 0;
    int          sent_count = 0;
    int          checked_count = 0;
    int          sat_count = 0;
    int          div0_count = 0;
    int          idle_cycles = 0;
    int          cycle_count = 0;
    int          ready_hold = 0;

    fixed_point_q24_8_alu DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic u64_t magnitude(input longint v);
        u64_t m;
        m = (v < 0) ? -v : v;
        return m;
    endfunction

    // exact Q24.8 arithmetic in 64 bits, then clamp to the word range
    function automatic alu_result_t alu_predict(input cmd_t op, input logic [31:0] a_raw,
                                                input logic [31:0] b_raw);
        longint      a;
        longint      b;
        longint      r;
        u64_t        prod;
        u64_t        num;
        u64_t        den;
        u64_t        quo;
        u64_t        rmd;
        logic        neg;
        alu_result_t o;
        a = longint'($signed(a_raw));
        b = longint'($signed(b_raw));
        r = 0;
        o = '0;
        neg = (a < 0) != (b < 0);
        case (op)
            CMD_ADD: r = a + b;
            CMD_SUB: r = a - b;
            CMD_MUL:
            begin
                prod = magnitude(a) * magnitude(b);
                quo = (prod + (u64_t'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
                r = neg ? -longint'(quo) : longint'(quo);
            end
            CMD_DIV:
            begin
                if (b == 0)
                begin
                    o.status = ST_DIV0;
                    return o;
                end
                num = magnitude(a) << FRAC_BITS;
                den = magnitude(b);
                quo = num / den;
                rmd = num % den;
                if (rmd >= den - rmd)
                    quo = quo + 1;     // half rounds away from zero
                r = neg ? -longint'(quo) : longint'(quo);
            end
            CMD_GT:  o.flag = (a > b);
            CMD_LT:  o.flag = (a < b);
            CMD_GE:  o.flag = (a >= b);
            CMD_LE:  o.flag = (a <= b);
            CMD_EQ:  o.flag = (a == b);
            CMD_NE:  o.flag = (a != b);
            CMD_MIN: r = (a < b) ? a : b;
            CMD_MAX: r = (a > b) ? a : b;
            CMD_INC: r = a + 1;
            CMD_DEC: r = a - 1;
            CMD_ITOF:
            begin
                num = magnitude(a) << FRAC_BITS;
                r = (a < 0) ? -longint'(num) : longint'(num);
            end
            default:
            begin
                num = magnitude(a) >> FRAC_BITS;
                r = (a < 0) ? -longint'(num) : longint'(num);
            end
        endcase
        if (r > WORD_HI)
        begin
            r = WORD_HI;
            o.status = ST_SAT;
        end
        else if (r < WORD_LO)
        begin
            r = WORD_LO;
            o.status = ST_SAT;
        end
        o.res = r[WORD_BITS-1:0];
        return o;
    endfunction

    // mostly back-to-back, some short gaps, a few long ones
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 88)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [31:0] pick_operand();
        logic [31:0] corners [0:7];
        corners = '{32'h00000000, 32'h00000001, 32'hffffffff, 32'h7fffffff,
                    32'h80000000, 32'h00000100, 32'hffffff00, 32'h00000080};
        case ($urandom_range(0, 9))
            0:       return corners[$urandom_range(0, 7)];
            1, 2, 3: return 32'($urandom_range(0, 8191)) - 32'd4096;
            4, 5:    return 32'($urandom_range(0, 32'h01ffffff)) - 32'h01000000;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_op(input cmd_t op, input logic [31:0] a, input logic [31:0] b,
                           input logic typed, input alu_result_t want, input bit no_gap);
        int gap;
        gap = no_gap ? 0 : pick_gap();
        // valid stays high across back-to-back transfers
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {b, a};
        s_tuser  <= op;
        do
            @(posedge clk);
        while (!s_tready);
        pending_results.push_back(typed ? want : alu_predict(op, a, b));
        sent_count++;
    endtask

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (ready_hold > 0)
        begin
            m_tready <= 1'b0;
            ready_hold <= ready_hold - 1;
        end
        else
        begin
            m_tready <= 1'b1;
            // stretch of steady readiness at the start of every window of cycle_count, random holds after it
            if ((cycle_count % 1500) >= 250)
                ready_hold <= pick_gap();
        end
    end

    always @(posedge clk)
    begin : check_results
        alu_result_t got;
        alu_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.res    = m_tdata[WORD_BITS-1:0];
            got.flag   = m_tdata[WORD_BITS];
            got.status = m_tuser;
            if (pending_results.size() == 0)
            begin
                $error("result transfer with nothing pending: result %h", got.res);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                checked_count++;
                if (want.status == ST_SAT)
                    sat_count++;
                if (want.status == ST_DIV0)
                    div0_count++;
                if (got.res !== want.res)
                begin
                    $error("result: expected %h, got %h", want.res, got.res);
                    fail_count++;
                end
                if (got.flag !== want.flag)
                begin
                    $error("flag: expected %b, got %b", want.flag, got.flag);
                    fail_count++;
                end
                if (got.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no transfer for %0d cycles, %0d results pending",
                     idle_cycles, pending_results.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        cmd_t        op;
        logic [31:0] a;
        logic [31:0] b;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (VECTORS[i])
            send_op(VECTORS[i].op, VECTORS[i].a, VECTORS[i].b, VECTORS[i].typed,
                    VECTORS[i].want, 1'b0);

        for (int n = 0; n < NUM_RANDOM; n++)
        begin
            op = cmd_t'($urandom_range(0, 15));
            a  = pick_operand();
            b  = pick_operand();
            if (op == CMD_DIV && $urandom_range(0, 9) == 0)
                b = '0;
            // one run of back-to-back transfers to fill the output buffer
            send_op(op, a, b, 1'b0, '0, (n >= 250 && n < 330));
        end
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d operations sent (%0d from the directed table), %0d results checked",
                 sent_count, NUM_VECTORS, checked_count);
        $display("%0d saturated results, %0d divisions by zero", sat_count, div0_count);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/q248_pkg.sv
rtl/core/q248_prep.sv
rtl/core/q248_cell.sv
rtl/core/q248_post.sv
rtl/core/fixed_point_q24_8_alu.sv
tb/fixed_point_q24_8_alu_test.sv
